[src/fcc_pkg.sv]
// Shared constants, types and register codes of the footprint collision check unit.
package fcc_pkg;

  localparam int MAP_COLS = 256;
  localparam int MAP_ROWS = 256;
  localparam int COL_W    = $clog2(MAP_COLS);
  localparam int ROW_W    = $clog2(MAP_ROWS);
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  localparam int POSE_W  = 21;
  localparam int DIFF_W  = POSE_W + 1;
  localparam int CPM_W   = 16;
  localparam int PROD_W  = DIFF_W + CPM_W + 1;
  localparam int FRAC_W  = 16;
  localparam int CLAMP_W = PROD_W - FRAC_W + 1;
  localparam int HALF_W  = 7;
  localparam int DIM_W   = 9;
  localparam int COST_W  = 8;
  localparam int CELL_W  = 8;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 21;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CPM        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_W     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_H     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd7;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic signed [POSE_W-1:0] origin_x;
    logic signed [POSE_W-1:0] origin_y;
    logic [CPM_W-1:0]         cpm;
    logic [HALF_W-1:0]        half_w;
    logic [HALF_W-1:0]        half_h;
    logic [DIM_W-1:0]         map_width;
    logic [DIM_W-1:0]         map_height;
  } fcc_geom_t;

  // One queued command: a cell write or a clamped query window.
  typedef struct packed {
    logic              is_query;
    logic              empty;
    logic [COL_W-1:0]  x0;
    logic [COL_W-1:0]  x1;
    logic [ROW_W-1:0]  y0;
    logic [ROW_W-1:0]  y1;
    logic [COST_W-1:0] cost;
  } fcc_cmd_t;

endpackage

[src/fcc_front.sv]
// Front end: takes items, converts query poses to clamped cell windows.
module fcc_front
  import fcc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  fcc_geom_t                   geom,
  input  logic                        s_valid,
  output logic                        s_ready,
  input  logic                        s_func,
  input  logic [CELL_W-1:0]           s_cell_x,
  input  logic [CELL_W-1:0]           s_cell_y,
  input  logic [COST_W-1:0]           s_cost,
  input  logic signed [POSE_W-1:0]    s_pose_x,
  input  logic signed [POSE_W-1:0]    s_pose_y,
  output logic                        q_push,
  input  logic                        q_ready,
  output fcc_cmd_t                    q_cmd
);

  logic                     va_r, vb_r;
  logic                     a_query_r, b_query_r;
  logic [CELL_W-1:0]        a_x_r, a_y_r, b_x_r, b_y_r;
  logic [COST_W-1:0]        a_cost_r, b_cost_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic signed [PROD_W-1:0] px_r, py_r;
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt;
  logic signed [PROD_W-1:0] px_nxt, py_nxt;
  logic signed [CLAMP_W-1:0] rx, ry, x0s, x1s, y0s, y1s, x0c, x1c, y0c, y1c, wm1, hm1;
  logic signed [CLAMP_W-1:0] hw, hh;
  logic keep, adv_b;

  assign dx_nxt = $signed({s_pose_x[POSE_W-1], s_pose_x})
                - $signed({geom.origin_x[POSE_W-1], geom.origin_x});
  assign dy_nxt = $signed({s_pose_y[POSE_W-1], s_pose_y})
                - $signed({geom.origin_y[POSE_W-1], geom.origin_y});

  assign px_nxt = $signed({{(PROD_W-DIFF_W){dx_r[DIFF_W-1]}}, dx_r})
                * $signed({{(PROD_W-CPM_W){1'b0}}, geom.cpm});
  assign py_nxt = $signed({{(PROD_W-DIFF_W){dy_r[DIFF_W-1]}}, dy_r})
                * $signed({{(PROD_W-CPM_W){1'b0}}, geom.cpm});

  // floor division by 2^16 is the arithmetic shift of the Q.16 product
  assign rx = $signed({px_r[PROD_W-1], px_r[PROD_W-1:FRAC_W]});
  assign ry = $signed({py_r[PROD_W-1], py_r[PROD_W-1:FRAC_W]});
  assign hw = $signed(CLAMP_W'(geom.half_w));
  assign hh = $signed(CLAMP_W'(geom.half_h));

  // last usable column/row; -1 when the map size is zero
  assign wm1 = (32'(geom.map_width) > 32'(MAP_COLS)) ? $signed(CLAMP_W'(MAP_COLS - 1))
             : $signed(CLAMP_W'(geom.map_width)) - $signed(CLAMP_W'(1));
  assign hm1 = (32'(geom.map_height) > 32'(MAP_ROWS)) ? $signed(CLAMP_W'(MAP_ROWS - 1))
             : $signed(CLAMP_W'(geom.map_height)) - $signed(CLAMP_W'(1));

  assign x0s = rx - hw;
  assign x1s = rx + hw;
  assign y0s = ry - hh;
  assign y1s = ry + hh;
  assign x0c = (x0s < 0) ? '0 : x0s;
  assign x1c = (x1s > wm1) ? wm1 : x1s;
  assign y0c = (y0s < 0) ? '0 : y0s;
  assign y1c = (y1s > hm1) ? hm1 : y1s;

  always_comb begin
    q_cmd = '0;
    q_cmd.is_query = b_query_r;
    if (b_query_r) begin
      q_cmd.empty = (x0c > x1c) || (y0c > y1c);
      q_cmd.x0    = COL_W'(x0c);
      q_cmd.x1    = COL_W'(x1c);
      q_cmd.y0    = ROW_W'(y0c);
      q_cmd.y1    = ROW_W'(y1c);
    end else begin
      q_cmd.x0   = COL_W'(b_x_r);
      q_cmd.y0   = ROW_W'(b_y_r);
      q_cmd.cost = b_cost_r;
    end
  end

  // writes outside the stored grid are dropped here
  assign keep    = b_query_r || ((32'(b_x_r) < 32'(MAP_COLS)) && (32'(b_y_r) < 32'(MAP_ROWS)));
  assign q_push  = vb_r && keep && q_ready;
  assign adv_b   = !vb_r || !keep || q_ready;
  assign s_ready = !va_r || adv_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (s_ready) va_r <= s_valid;
      if (adv_b)   vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      a_query_r <= (s_func == FUNC_QUERY);
      a_x_r     <= s_cell_x;
      a_y_r     <= s_cell_y;
      a_cost_r  <= s_cost;
      dx_r      <= dx_nxt;
      dy_r      <= dy_nxt;
    end
    if (adv_b && va_r) begin
      b_query_r <= a_query_r;
      b_x_r     <= a_x_r;
      b_y_r     <= a_y_r;
      b_cost_r  <= a_cost_r;
      px_r      <= px_nxt;
      py_r      <= py_nxt;
    end
  end

endmodule

[src/fcc_fifo.sv]
// Short command queue between the front end and the scan engine.
module fcc_fifo
  import fcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  fcc_cmd_t push_cmd,
  output logic     ready,
  input  logic     pop,
  output logic     valid,
  output fcc_cmd_t head
);

  fcc_cmd_t              slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_r, rp_r;
  logic [FIFO_PTR_W:0]   cnt_r;

  assign ready = (32'(cnt_r) < 32'(FIFO_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_cmd;
  end

endmodule

[src/fcc_back.sv]
// Back end: cost grid memory, cell writes, window scan and result register.
module fcc_back
  import fcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [COST_W-1:0] threshold,
  input  logic              q_valid,
  input  fcc_cmd_t          q_head,
  output logic              q_pop,
  output logic              m_valid,
  input  logic              m_ready,
  output logic              m_collision,
  output logic              m_empty
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [COST_W-1:0] mem [MEM_DEPTH];
  logic [COST_W-1:0] rd_data_r;
  logic [1:0]        state_r, state_nxt;
  logic [COL_W-1:0]  x_r, x1_r;
  logic [ROW_W-1:0]  y_r, y0_r, y1_r;
  logic              rd_v_r, rd_last_r, hit_r;
  logic              out_valid_r, out_coll_r, out_empty_r;
  logic              out_free, last_addr, mem_we, start_scan;
  logic              load_out, load_coll, load_empty;

  assign out_free  = !out_valid_r || m_ready;
  assign last_addr = (x_r == x1_r) && (y_r == y1_r);

  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    start_scan = 1'b0;
    load_out   = 1'b0;
    load_coll  = 1'b0;
    load_empty = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (!q_head.is_query) begin
            mem_we = 1'b1;
            q_pop  = 1'b1;
          end else if (q_head.empty) begin
            if (out_free) begin
              q_pop      = 1'b1;
              load_out   = 1'b1;
              load_empty = 1'b1;
            end
          end else begin
            q_pop      = 1'b1;
            start_scan = 1'b1;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: if (last_addr) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          load_out  = 1'b1;
          load_coll = hit_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == S_SCAN);
      if (load_out)     out_valid_r <= 1'b1;
      else if (m_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_last_r <= last_addr;
    if (start_scan) begin
      x_r   <= q_head.x0;
      x1_r  <= q_head.x1;
      y_r   <= q_head.y0;
      y0_r  <= q_head.y0;
      y1_r  <= q_head.y1;
      hit_r <= 1'b0;
    end else begin
      if (state_r == S_SCAN) begin
        if (y_r == y1_r) begin
          y_r <= y0_r;
          x_r <= x_r + 1'b1;
        end else begin
          y_r <= y_r + 1'b1;
        end
      end
      if (rd_v_r && (rd_data_r >= threshold)) hit_r <= 1'b1;
    end
    if (load_out) begin
      out_coll_r  <= load_coll;
      out_empty_r <= load_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[{q_head.y0, q_head.x0}] <= q_head.cost;
    rd_data_r <= mem[{y_r, x_r}];
  end

  assign m_valid     = out_valid_r;
  assign m_collision = out_coll_r;
  assign m_empty     = out_empty_r;

`ifndef SYNTH
  a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (x_r <= x1_r) && (y_r <= y1_r))
    else $error("scan address left the window");

  a_fin_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> rd_v_r && rd_last_r)
    else $error("scan finished without the last cell read");

  a_pop_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE) && q_valid)
    else $error("queue popped outside idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !m_ready) |=> out_valid_r && $stable(out_coll_r) && $stable(out_empty_r))
    else $error("pending result overwritten");
`endif

endmodule

[src/footprint_collision_check_unit.sv]
// Top level of the footprint collision check unit: config registers and wiring.
//
// channel  direction  handshake          payload
// in_      slave      tvalid/tready      tdata: cell_x, cell_y, cell_cost, pose_x, pose_y;
//                                        tuser: func
// out_     master     tvalid/tready      tdata: in_collision, window_empty
// cfg_     write      cfg_we             cfg_index, cfg_data
//
// A write item is handled by the back end straight from idle; a query holds the scan
// engine until its result is loaded, with one grid read per cell
// through the single read port of the cost memory. Off-map queries skip the scan.
// The front end (2-stage pose multiply pipeline) runs ahead through a 4-entry queue.
// Reset is synchronous; the cost grid is not cleared and must be written before use.
module footprint_collision_check_unit
  import fcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [7:0] cell_x, [15:8] cell_y, [23:16] cell_cost, [44:24] pose_x, [65:45] pose_y
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] func
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] in_collision, [1] window_empty
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  fcc_geom_t         geom_r;
  logic [COST_W-1:0] thr_r;
  logic              q_push, q_ready, q_pop, q_valid;
  fcc_cmd_t          q_in, q_head;
  logic              coll, empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.origin_x   <= '0;
      geom_r.origin_y   <= '0;
      geom_r.cpm        <= CPM_W'(5120);
      geom_r.half_w     <= HALF_W'(2);
      geom_r.half_h     <= HALF_W'(2);
      geom_r.map_width  <= DIM_W'(256);
      geom_r.map_height <= DIM_W'(256);
      thr_r             <= COST_W'(253);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:   geom_r.origin_x   <= $signed(cfg_data[POSE_W-1:0]);
        CFG_ORIGIN_Y:   geom_r.origin_y   <= $signed(cfg_data[POSE_W-1:0]);
        CFG_CPM:        geom_r.cpm        <= cfg_data[CPM_W-1:0];
        CFG_HALF_W:     geom_r.half_w     <= cfg_data[HALF_W-1:0];
        CFG_HALF_H:     geom_r.half_h     <= cfg_data[HALF_W-1:0];
        CFG_MAP_WIDTH:  geom_r.map_width  <= cfg_data[DIM_W-1:0];
        CFG_MAP_HEIGHT: geom_r.map_height <= cfg_data[DIM_W-1:0];
        CFG_THRESHOLD:  thr_r             <= cfg_data[COST_W-1:0];
        default: ;
      endcase
    end
  end

  fcc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .geom     (geom_r),
    .s_valid  (in_tvalid),
    .s_ready  (in_tready),
    .s_func   (in_tuser),
    .s_cell_x (in_tdata[7:0]),
    .s_cell_y (in_tdata[15:8]),
    .s_cost   (in_tdata[23:16]),
    .s_pose_x ($signed(in_tdata[44:24])),
    .s_pose_y ($signed(in_tdata[65:45])),
    .q_push   (q_push),
    .q_ready  (q_ready),
    .q_cmd    (q_in)
  );

  fcc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  fcc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .threshold   (thr_r),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .m_valid     (out_tvalid),
    .m_ready     (out_tready),
    .m_collision (coll),
    .m_empty     (empty)
  );

  assign out_tdata = {{(OUT_TDATA_W-2){1'b0}}, empty, coll};

endmodule

[tb/fcc_tb_pkg.sv]
// Item layout and self-checking collision scoreboard for the footprint check testbench.
`timescale 1ns / 100ps

package fcc_tb_pkg;
  import fcc_pkg::*;

  // in_tdata layout, lowest field last
  typedef struct packed {
    logic [IN_TDATA_W-2*POSE_W-3*CELL_W-1:0] pad;
    logic [POSE_W-1:0]                       pose_y;
    logic [POSE_W-1:0]                       pose_x;
    logic [COST_W-1:0]                       cell_cost;
    logic [CELL_W-1:0]                       cell_y;
    logic [CELL_W-1:0]                       cell_x;
  } grid_item_t;

  typedef struct {
    logic hit;
    logic empty;
  } verdict_t;

  class collision_checker;
    logic [COST_W-1:0] cost_grid [MEM_DEPTH];
    fcc_geom_t         geom;
    logic [COST_W-1:0] threshold;
    verdict_t          expected_verdicts [$];
    int unsigned       mismatches;

    function new();
      geom.origin_x   = '0;
      geom.origin_y   = '0;
      geom.cpm        = 16'd5120;
      geom.half_w     = 7'd2;
      geom.half_h     = 7'd2;
      geom.map_width  = 9'd256;
      geom.map_height = 9'd256;
      threshold       = 8'd253;
      mismatches      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_ORIGIN_X:   geom.origin_x   = val[POSE_W-1:0];
        CFG_ORIGIN_Y:   geom.origin_y   = val[POSE_W-1:0];
        CFG_CPM:        geom.cpm        = val[CPM_W-1:0];
        CFG_HALF_W:     geom.half_w     = val[HALF_W-1:0];
        CFG_HALF_H:     geom.half_h     = val[HALF_W-1:0];
        CFG_MAP_WIDTH:  geom.map_width  = val[DIM_W-1:0];
        CFG_MAP_HEIGHT: geom.map_height = val[DIM_W-1:0];
        CFG_THRESHOLD:  threshold       = val[COST_W-1:0];
        default: ;
      endcase
    endfunction

    // floor((pose - origin) * cpm / 2^16), exact in 64 bits
    function longint pose_to_cell(logic [POSE_W-1:0] pose, logic [POSE_W-1:0] org);
      longint d;
      d = longint'($signed(pose)) - longint'($signed(org));
      return (d * longint'(geom.cpm)) >>> FRAC_W;
    endfunction

    function verdict_t predict_collision(grid_item_t item);
      longint   rx, ry, x0, x1, y0, y1, w, h, x, y;
      verdict_t v;
      w  = (geom.map_width > MAP_COLS) ? MAP_COLS : longint'(geom.map_width);
      h  = (geom.map_height > MAP_ROWS) ? MAP_ROWS : longint'(geom.map_height);
      rx = pose_to_cell(item.pose_x, geom.origin_x);
      ry = pose_to_cell(item.pose_y, geom.origin_y);
      x0 = rx - longint'(geom.half_w);
      x1 = rx + longint'(geom.half_w);
      y0 = ry - longint'(geom.half_h);
      y1 = ry + longint'(geom.half_h);
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > w - 1) x1 = w - 1;
      if (y1 > h - 1) y1 = h - 1;
      v.hit   = 1'b0;
      v.empty = 1'b0;
      if (x0 > x1 || y0 > y1) begin
        v.empty = 1'b1;
      end else begin
        for (x = x0; x <= x1 && !v.hit; x++) begin
          for (y = y0; y <= y1 && !v.hit; y++) begin
            if (cost_grid[int'(y * MAP_COLS + x)] >= threshold) v.hit = 1'b1;
          end
        end
      end
      return v;
    endfunction

    function void note_item(logic func, grid_item_t item);
      if (func == FUNC_WRITE) begin
        cost_grid[{item.cell_y, item.cell_x}] = item.cell_cost;
      end else begin
        expected_verdicts.push_back(predict_collision(item));
      end
    endfunction

    function int unsigned outstanding();
      return expected_verdicts.size();
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_verdict(logic [OUT_TDATA_W-1:0] data);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("result %b with nothing pending", data[1:0]));
        return;
      end
      want = expected_verdicts.pop_front();
      if (data[0] !== want.hit)
        report_mismatch($sformatf("in_collision %b, predicted %b", data[0], want.hit));
      if (data[1] !== want.empty)
        report_mismatch($sformatf("window_empty %b, predicted %b", data[1], want.empty));
    endtask
  endclass

endpackage

[tb/tb_footprint_collision_check_unit.sv]
// Testbench top for the footprint collision check unit: stimulus, result sink and timeout.
`timescale 1ns / 100ps

module tb_footprint_collision_check_unit;
  import fcc_pkg::*;
  import fcc_tb_pkg::*;

  localparam int                       CYCLE_LIMIT   = 2_000_000;
  localparam int                       SETTLE_CYCLES = 32;
  localparam int                       FILL_CELLS    = 16;
  localparam int                       PATCH_CELLS   = 8;
  localparam logic signed [POSE_W-1:0] POSE_MAX      = POSE_W'(1048575);
  localparam logic signed [POSE_W-1:0] POSE_MIN      = POSE_W'(-1048576);

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  collision_checker sb;
  int unsigned      cycle_count = 0;
  int               rx_hold     = 0;
  bit               no_gaps     = 1'b0;

  footprint_collision_check_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(input logic func, input grid_item_t item);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= item;
    do @(posedge clk); while (!in_tready);
    sb.note_item(func, item);
  endtask

  // unused fields carry noise, the block must ignore them
  task automatic write_cell(input logic [CELL_W-1:0] x, input logic [CELL_W-1:0] y,
                            input logic [COST_W-1:0] cost);
    grid_item_t item;
    item.pad       = '0;
    item.pose_x    = POSE_W'($urandom);
    item.pose_y    = POSE_W'($urandom);
    item.cell_cost = cost;
    item.cell_y    = y;
    item.cell_x    = x;
    send_item(FUNC_WRITE, item);
  endtask

  task automatic query_at(input logic [POSE_W-1:0] px, input logic [POSE_W-1:0] py);
    grid_item_t item;
    item.pad       = '0;
    item.pose_x    = px;
    item.pose_y    = py;
    item.cell_cost = COST_W'($urandom);
    item.cell_y    = CELL_W'($urandom);
    item.cell_x    = CELL_W'($urandom);
    send_item(FUNC_QUERY, item);
  endtask

  // waits out every pending result, plus the write path behind it
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic [POSE_W-1:0] ox, input logic [POSE_W-1:0] oy,
                              input logic [CPM_W-1:0] cpm, input logic [HALF_W-1:0] hw,
                              input logic [HALF_W-1:0] hh, input logic [DIM_W-1:0] mw,
                              input logic [DIM_W-1:0] mh, input logic [COST_W-1:0] thr);
    logic [CFG_IDX_W-1:0]  regs [8];
    logic [CFG_DATA_W-1:0] vals [8];
    regs = '{CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_CPM, CFG_HALF_W,
             CFG_HALF_H, CFG_MAP_WIDTH, CFG_MAP_HEIGHT, CFG_THRESHOLD};
    vals = '{CFG_DATA_W'(ox), CFG_DATA_W'(oy), CFG_DATA_W'(cpm), CFG_DATA_W'(hw),
             CFG_DATA_W'(hh), CFG_DATA_W'(mw), CFG_DATA_W'(mh), CFG_DATA_W'(thr)};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // map kept inside the filled block so every scanned cell has been written
  task automatic random_config();
    logic [POSE_W-1:0] ox, oy;
    logic [DIM_W-1:0]  mw, mh;
    ox = ($urandom_range(0, 3) == 0) ? POSE_W'($urandom) : POSE_W'($urandom_range(0, 1024) - 512);
    oy = ($urandom_range(0, 3) == 0) ? POSE_W'($urandom) : POSE_W'($urandom_range(0, 1024) - 512);
    mw = DIM_W'($urandom_range(1, FILL_CELLS));
    mh = DIM_W'($urandom_range(1, FILL_CELLS));
    apply_config(ox, oy, CPM_W'($urandom_range(256, 12800)),
                 HALF_W'($urandom_range(0, 4)), HALF_W'($urandom_range(0, 4)), mw, mh,
                 $urandom_range(0, 1) ? COST_W'($urandom_range(200, 255))
                                      : COST_W'($urandom_range(0, 255)));
  endtask

  // pose landing inside the given cell under the current geometry
  function automatic logic [POSE_W-1:0] pose_for_cell(input int cell_idx,
                                                       input logic [POSE_W-1:0] org);
    longint p;
    if (sb.geom.cpm == 0) begin
      p = longint'($signed(org)) + longint'($urandom_range(0, 4095)) - 2048;
    end else begin
      p = longint'($signed(org)) +
          (longint'(cell_idx) * 65536 + longint'($urandom_range(0, 65535))) /
          longint'(sb.geom.cpm);
    end
    if (p > POSE_MAX) p = POSE_MAX;
    if (p < POSE_MIN) p = POSE_MIN;
    return p[POSE_W-1:0];
  endfunction

  task automatic random_items(input int count);
    int w, h, cx, cy, roll;
    w = (sb.geom.map_width > MAP_COLS) ? MAP_COLS : int'(sb.geom.map_width);
    h = (sb.geom.map_height > MAP_ROWS) ? MAP_ROWS : int'(sb.geom.map_height);
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        if ($urandom_range(0, 3) == 0) begin
          write_cell(CELL_W'($urandom), CELL_W'($urandom), COST_W'($urandom));
        end else begin
          write_cell(CELL_W'($urandom_range(0, FILL_CELLS - 1)),
                     CELL_W'($urandom_range(0, FILL_CELLS - 1)), COST_W'($urandom));
        end
      end else if (roll < 88) begin
        cx = int'($urandom_range(0, w + 15)) - 8;
        cy = int'($urandom_range(0, h + 15)) - 8;
        query_at(pose_for_cell(cx, sb.geom.origin_x), pose_for_cell(cy, sb.geom.origin_y));
      end else begin
        query_at(POSE_W'($urandom), POSE_W'($urandom));
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_verdict(out_tdata);
    end
  end

  initial begin : stimulus
    sb = new();
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= FUNC_WRITE;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_ORIGIN_X;
    cfg_data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // grid has no reset: fill the low corner block and a patch at the far corner
    // back to back; every query window below stays inside them
    no_gaps = 1'b1;
    for (int y = 0; y < FILL_CELLS; y++) begin
      for (int x = 0; x < FILL_CELLS; x++) begin
        write_cell(CELL_W'(x), CELL_W'(y), COST_W'($urandom));
      end
    end
    for (int y = MAP_ROWS - PATCH_CELLS; y < MAP_ROWS; y++) begin
      for (int x = MAP_COLS - PATCH_CELLS; x < MAP_COLS; x++) begin
        write_cell(CELL_W'(x), CELL_W'(y), COST_W'($urandom));
      end
    end
    no_gaps = 1'b0;

    // reset geometry: corners, far off map either side, lethal cells
    query_at('0, '0);
    query_at(POSE_MAX, POSE_MAX);
    query_at(POSE_MIN, POSE_MIN);
    query_at(POSE_MIN, '0);
    write_cell(8'd255, 8'd255, 8'd255);
    write_cell(8'd0, 8'd0, 8'd0);
    write_cell(8'd6, 8'd5, 8'd253);
    query_at(POSE_W'(70), POSE_W'(70));
    write_cell(8'd14, 8'd14, 8'd252);
    query_at(POSE_W'(179), POSE_W'(179));
    query_at(POSE_W'(3264), POSE_W'(3264));

    // zero resolution, origins at the extremes: every pose is cell 0
    wait_idle();
    apply_config(POSE_MIN, POSE_MAX, 16'd0, 7'd0, 7'd0, 9'd256, 9'd256, 8'd255);
    query_at(POSE_MAX, POSE_MIN);
    query_at(POSE_MIN, POSE_MAX);
    write_cell(8'd0, 8'd0, 8'd255);
    query_at('0, '0);

    // full resolution, threshold 0
    wait_idle();
    apply_config(POSE_MIN, POSE_MAX, 16'hFFFF, 7'd127, 7'd127, 9'd16, 9'd16, 8'd0);
    query_at(POSE_MIN, POSE_MAX);
    query_at(POSE_MAX, POSE_MIN);

    // map larger than the grid: far corner windows clip at the last column and row
    wait_idle();
    apply_config('0, '0, 16'd5120, 7'd3, 7'd3, 9'd511, 9'd511, 8'd253);
    query_at(POSE_W'(3260), POSE_W'(3260));
    query_at(POSE_W'(3300), POSE_W'(3300));
    query_at(POSE_W'(3400), POSE_W'(3400));

    // zero map width
    wait_idle();
    apply_config('0, '0, 16'd5120, 7'd1, 7'd1, 9'd0, 9'd1, 8'd0);
    query_at(POSE_W'(100), '0);
    query_at('0, '0);

    // widest footprint, whole map scanned
    wait_idle();
    apply_config('0, '0, 16'd5120, 7'd127, 7'd127, 9'd16, 9'd16, 8'd255);
    query_at(POSE_W'(102), POSE_W'(102));

    for (int ph = 0; ph < 12; ph++) begin
      wait_idle();
      random_config();
      // long sink hold-off while the source keeps pushing
      if (ph == 2) rx_hold = 400;
      no_gaps = (ph % 4 == 3);
      random_items(42);
    end

    wait_idle();
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
